// ===== rtl/mac_pkg.sv =====
// ----------------------------------------------------------------------------
// mac_pkg
// Shared types and constants of the magnetometer axis calibration block.
// ----------------------------------------------------------------------------
package mac_pkg;

  typedef logic signed [15:0] s16_t;
  typedef logic signed [14:0] s15_t;
  typedef logic signed [31:0] s32_t;
  typedef logic signed [47:0] s48_t;

  typedef struct packed {
    logic [47:0]      adc_offsets;
    logic [47:0]      axis_gains;
    logic [2:0][47:0] matrix_rows;
    logic [47:0]      cal_offsets;
    logic             calibration_mode_on;
    logic             factory_range_on;
  } cfg_t;

  localparam logic [2:0] RegAdcOffsets  = 3'd0;
  localparam logic [2:0] RegAxisGains   = 3'd1;
  localparam logic [2:0] RegMatrixRowX  = 3'd2;
  localparam logic [2:0] RegMatrixRowY  = 3'd3;
  localparam logic [2:0] RegMatrixRowZ  = 3'd4;
  localparam logic [2:0] RegCalOffsets  = 3'd5;
  localparam logic [2:0] RegCalMode     = 3'd6;
  localparam logic [2:0] RegFactoryMode = 3'd7;

  localparam logic [47:0] GainsReset = 48'h1000_1000_1000;
  localparam logic [47:0] RowXReset  = 48'h0000_0000_4000;
  localparam logic [47:0] RowYReset  = 48'h0000_4000_0000;
  localparam logic [47:0] RowZReset  = 48'h4000_0000_0000;

  localparam int unsigned FracBits     = 26;
  localparam s16_t        LimitNormal  = 16'sd10000;
  localparam s16_t        LimitFactory = 16'sd12000;
  // floor(a * 16384 / 10000) == (a * WordMagic) >> WordShift for a <= 12000
  localparam logic [24:0] WordMagic    = 25'd27487791;
  localparam int unsigned WordShift    = 24;

  function automatic s16_t lane(input logic [47:0] packed_v, input logic [1:0] k);
    s16_t r;
    r = packed_v[16*k +: 16];
    return r;
  endfunction

endpackage

// ===== rtl/mac_if.sv =====
// ----------------------------------------------------------------------------
// mac_in_if / mac_out_if
// Valid/ready channels for samples in and corrected results out.
// ----------------------------------------------------------------------------
interface mac_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_x;
  logic signed [15:0] sample_y;
  logic signed [15:0] sample_z;

  modport source (output valid, output sample_x, output sample_y, output sample_z,
                  input ready);
  modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                  output ready);
endinterface

interface mac_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] field_x;
  logic signed [14:0] field_y;
  logic signed [14:0] field_z;
  logic signed [15:0] word_x;
  logic signed [15:0] word_y;
  logic signed [15:0] word_z;

  modport source (output valid, output field_x, output field_y, output field_z,
                  output word_x, output word_y, output word_z, input ready);
  modport sink   (input valid, input field_x, input field_y, input field_z,
                  input word_x, input word_y, input word_z, output ready);
endinterface

// ===== rtl/magnetometer_axis_calibration.sv =====
// ----------------------------------------------------------------------------
// magnetometer_axis_calibration
// Per-axis offset and gain, misalignment matrix, calibration offset, clamp
// and scaled word output for three-axis magnetometer samples.
// Pipeline: 7 register stages, the first loaded at the input transfer edge.
// Throughput: one sample per cycle; each stage stalls only when its own
// output is held, so bubbles fill while the output waits.
// Reset: all stage valid bits clear, registers return to unity gain,
// identity matrix, zero offsets, normal range and calibration mode off.
// ----------------------------------------------------------------------------
module magnetometer_axis_calibration (
  input  logic        clk_i,
  input  logic        rst_ni,
  mac_in_if.sink      sample_i,
  mac_out_if.source   result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import mac_pkg::*;

  cfg_t             cfg;
  logic [2:0][15:0] samples;
  logic             fr_valid, fr_ready;
  logic [2:0][31:0] gained;
  logic             mx_valid, mx_ready;
  logic [2:0][15:0] rows;
  logic [2:0][14:0] fields;
  logic [2:0][15:0] words;

  assign samples = {sample_i.sample_z, sample_i.sample_y, sample_i.sample_x};

  mac_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mac_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .valid_i  (sample_i.valid),
    .ready_o  (sample_i.ready),
    .sample_i (samples),
    .valid_o  (fr_valid),
    .ready_i  (fr_ready),
    .gained_o (gained)
  );

  mac_matrix u_matrix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .valid_i  (fr_valid),
    .ready_o  (fr_ready),
    .gained_i (gained),
    .valid_o  (mx_valid),
    .ready_i  (mx_ready),
    .row_o    (rows)
  );

  mac_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (mx_valid),
    .ready_o (mx_ready),
    .row_i   (rows),
    .valid_o (result_o.valid),
    .ready_i (result_o.ready),
    .field_o (fields),
    .word_o  (words)
  );

  assign result_o.field_x = fields[0];
  assign result_o.field_y = fields[1];
  assign result_o.field_z = fields[2];
  assign result_o.word_x  = words[0];
  assign result_o.word_y  = words[1];
  assign result_o.word_z  = words[2];

endmodule

// ===== rtl/mac_cfg.sv =====
// ----------------------------------------------------------------------------
// mac_cfg
// APB register file holding offsets, gains, matrix and mode bits.
// ----------------------------------------------------------------------------
module mac_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready,
  output mac_pkg::cfg_t cfg_o
);
  import mac_pkg::*;

  cfg_t       cfg_q;
  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[5:3];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.adc_offsets         <= '0;
      cfg_q.axis_gains          <= GainsReset;
      cfg_q.matrix_rows[0]      <= RowXReset;
      cfg_q.matrix_rows[1]      <= RowYReset;
      cfg_q.matrix_rows[2]      <= RowZReset;
      cfg_q.cal_offsets         <= '0;
      cfg_q.calibration_mode_on <= 1'b0;
      cfg_q.factory_range_on    <= 1'b0;
    end else if (wr) begin
      case (idx)
        RegAdcOffsets:  cfg_q.adc_offsets         <= pwdata[47:0];
        RegAxisGains:   cfg_q.axis_gains          <= pwdata[47:0];
        RegMatrixRowX:  cfg_q.matrix_rows[0]      <= pwdata[47:0];
        RegMatrixRowY:  cfg_q.matrix_rows[1]      <= pwdata[47:0];
        RegMatrixRowZ:  cfg_q.matrix_rows[2]      <= pwdata[47:0];
        RegCalOffsets:  cfg_q.cal_offsets         <= pwdata[47:0];
        RegCalMode:     cfg_q.calibration_mode_on <= pwdata[0];
        RegFactoryMode: cfg_q.factory_range_on    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegAdcOffsets:  prdata = {16'd0, cfg_q.adc_offsets};
      RegAxisGains:   prdata = {16'd0, cfg_q.axis_gains};
      RegMatrixRowX:  prdata = {16'd0, cfg_q.matrix_rows[0]};
      RegMatrixRowY:  prdata = {16'd0, cfg_q.matrix_rows[1]};
      RegMatrixRowZ:  prdata = {16'd0, cfg_q.matrix_rows[2]};
      RegCalOffsets:  prdata = {16'd0, cfg_q.cal_offsets};
      RegCalMode:     prdata = {63'd0, cfg_q.calibration_mode_on};
      RegFactoryMode: prdata = {63'd0, cfg_q.factory_range_on};
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== rtl/mac_front.sv =====
// ----------------------------------------------------------------------------
// mac_front
// Stages 1-2: ADC offset removal (16-bit wrap) and Q4.12 axis gain.
// ----------------------------------------------------------------------------
module mac_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mac_pkg::cfg_t         cfg_i,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [2:0][15:0]      sample_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [2:0][31:0]      gained_o
);
  import mac_pkg::*;

  logic v1_q, v2_q;
  logic en1, en2;
  s16_t d_q [3];
  s32_t g_q [3];

  assign en2     = ~v2_q | ready_i;
  assign en1     = ~v1_q | en2;
  assign ready_o = en1;
  assign valid_o = v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_axis
    always_ff @(posedge clk_i) begin
      if (en1) d_q[k] <= s16_t'(sample_i[k]) - lane(cfg_i.adc_offsets, 2'(k));
      if (en2) g_q[k] <= d_q[k] * lane(cfg_i.axis_gains, 2'(k));
    end
    assign gained_o[k] = g_q[k];
  end

endmodule

// ===== rtl/mac_matrix.sv =====
// ----------------------------------------------------------------------------
// mac_matrix
// Stages 3-4: 3x3 Q2.14 misalignment products, row sums, truncation toward
// zero and 16-bit saturation.
// ----------------------------------------------------------------------------
module mac_matrix (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mac_pkg::cfg_t         cfg_i,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [2:0][31:0]      gained_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [2:0][15:0]      row_o
);
  import mac_pkg::*;

  logic v3_q, v4_q;
  logic en3, en4;
  s48_t p_q [3][3];
  s16_t r_q [3];

  logic signed [49:0] sum [3];
  logic signed [49:0] adj [3];
  logic signed [23:0] sh  [3];
  s16_t               sat [3];

  assign en4     = ~v4_q | ready_i;
  assign en3     = ~v3_q | en4;
  assign ready_o = en3;
  assign valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en3) v3_q <= valid_i;
      if (en4) v4_q <= v3_q;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      always_ff @(posedge clk_i) begin
        if (en3) p_q[i][j] <= s32_t'(gained_i[j]) * lane(cfg_i.matrix_rows[i], 2'(j));
      end
    end

    always_comb begin
      sum[i] = 50'(p_q[i][0]) + 50'(p_q[i][1]) + 50'(p_q[i][2]);
      // bias negatives so the arithmetic shift rounds toward zero
      adj[i] = sum[i] + (sum[i][49] ? 50'sd67108863 : 50'sd0);
      sh[i]  = 24'(adj[i] >>> FracBits);
      if (sh[i] > 24'sd32767) begin
        sat[i] = 16'sd32767;
      end else if (sh[i] < -24'sd32768) begin
        sat[i] = -16'sd32768;
      end else begin
        sat[i] = sh[i][15:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en4) r_q[i] <= sat[i];
    end
    assign row_o[i] = r_q[i];
  end

endmodule

// ===== rtl/mac_post.sv =====
// ----------------------------------------------------------------------------
// mac_post
// Stages 5-7: calibration offset (not applied in calibration mode), range clamp and scaled word output.
// ----------------------------------------------------------------------------
module mac_post (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mac_pkg::cfg_t         cfg_i,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [2:0][15:0]      row_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [2:0][14:0]      field_o,
  output logic [2:0][15:0]      word_o
);
  import mac_pkg::*;

  logic v5_q, v6_q, v7_q;
  logic en5, en6, en7;
  s16_t lim, lim_n;

  s15_t        f5_q [3];
  s15_t        f6_q [3];
  logic        n6_q [3];
  logic [38:0] m6_q [3];
  s15_t        f7_q [3];
  s16_t        w7_q [3];

  s16_t        cor [3];
  s15_t        clp [3];
  logic [13:0] mag [3];
  logic [14:0] wmag [3];

  assign en7     = ~v7_q | ready_i;
  assign en6     = ~v6_q | en7;
  assign en5     = ~v5_q | en6;
  assign ready_o = en5;
  assign valid_o = v7_q;

  assign lim   = cfg_i.factory_range_on ? LimitFactory : LimitNormal;
  assign lim_n = 16'sd0 - lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (en5) v5_q <= valid_i;
      if (en6) v6_q <= v5_q;
      if (en7) v7_q <= v6_q;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_axis
    always_comb begin
      cor[k] = cfg_i.calibration_mode_on ? s16_t'(row_i[k])
                                         : s16_t'(row_i[k]) - lane(cfg_i.cal_offsets, 2'(k));
      if (cor[k] > lim) begin
        clp[k] = lim[14:0];
      end else if (cor[k] < lim_n) begin
        clp[k] = lim_n[14:0];
      end else begin
        clp[k] = cor[k][14:0];
      end
      mag[k]  = f5_q[k][14] ? 14'(15'sd0 - f5_q[k]) : f5_q[k][13:0];
      wmag[k] = m6_q[k][38:WordShift];
    end

    always_ff @(posedge clk_i) begin
      if (en5) f5_q[k] <= clp[k];
      if (en6) begin
        f6_q[k] <= f5_q[k];
        n6_q[k] <= f5_q[k][14];
        m6_q[k] <= 39'(mag[k]) * 39'(WordMagic);
      end
      if (en7) begin
        f7_q[k] <= f6_q[k];
        w7_q[k] <= n6_q[k] ? 16'sd0 - s16_t'({1'b0, wmag[k]}) : s16_t'({1'b0, wmag[k]});
      end
    end

    assign field_o[k] = f7_q[k];
    assign word_o[k]  = w7_q[k];
  end

endmodule

// ===== rtl/mac_checker.sv =====
// ----------------------------------------------------------------------------
// mac_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module mac_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [14:0] field_x_i,
  input logic signed [15:0] word_x_i,
  input logic signed [14:0] field_z_i,
  input logic signed [15:0] word_z_i
);

  a_valid_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped before transfer");

  a_data_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(field_x_i) && $stable(word_x_i))
    else $error("stalled result changed");

  a_field_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> field_x_i <= 15'sd12000 && field_x_i >= -15'sd12000 &&
                    field_z_i <= 15'sd12000 && field_z_i >= -15'sd12000)
    else $error("field outside clamp range");

  a_word_sign : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (field_x_i[14] == word_x_i[15]) &&
                    ((field_x_i == 15'sd0) == (word_x_i == 16'sd0)) &&
                    (field_z_i[14] == word_z_i[15]))
    else $error("scaled word disagrees with field sign");

endmodule

bind magnetometer_axis_calibration mac_checker u_mac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .field_x_i   (result_o.field_x),
  .word_x_i    (result_o.word_x),
  .field_z_i   (result_o.field_z),
  .word_z_i    (result_o.word_z)
);
